// ===== hw/rtl/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants of the matrix multiply engine
// Field widths, request and register codes, and the structs passed between
// the sequencer and the chain of multiply-accumulate cells.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int DIM_W  = 4;   // width of a dimension register and loop counters
  localparam int IDX_W  = 3;   // width of a row or column index field
  localparam int VAL_W  = 16;  // Q8.8 element width
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = PROD_W + DIM_W;  // room for up to 15 products
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 2'd2;

  // One element of a row of A travelling down the cell chain.
  typedef struct packed {
    logic                    valid;
    logic                    first;
    logic                    last;
    logic [DIM_W-1:0]        k;
    logic signed [VAL_W-1:0] a;
  } mme_tok_t;

  // Write of one element of B, steered to the cell that owns its column.
  typedef struct packed {
    logic                    en;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } mme_wr_t;

endpackage

// ===== hw/rtl/mme_ram.sv =====
// ----------------------------------------------------------------------------
// mme_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  clk,
  wr_en,
  wr_addr,
  wr_data,
  rd_addr,
  rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             wr_en;
  input  logic [AW-1:0]    wr_addr;
  input  logic [WIDTH-1:0] wr_data;
  input  logic [AW-1:0]    rd_addr;
  output logic [WIDTH-1:0] rd_data;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/mme_cell.sv =====
// ----------------------------------------------------------------------------
// mme_cell: one column cell of the multiply-accumulate chain
// Holds one column of B, multiplies each passing element of A by the matching
// B entry, accumulates over k, then rounds the finished sum to Q8.8 and saturates.
// ----------------------------------------------------------------------------
module mme_cell import mme_pkg::*; #(
  parameter int COL       = 0,
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clr,
  input  mme_wr_t                 wr,
  input  mme_tok_t                tok_in,
  output mme_tok_t                tok_out,
  output logic signed [VAL_W-1:0] res_value,
  output logic                    res_valid
);
  localparam int RAW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic signed [ACC_W-1:0] HALF = (ACC_W'(1) << FRAC_BITS) >> 1;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

  logic [VAL_W-1:0]         b_raw;
  mme_tok_t                 tok1;
  logic signed [PROD_W-1:0] prod;
  logic                     v2, first2, last2;
  logic signed [ACC_W-1:0]  acc;
  logic                     done3;
  logic signed [ACC_W-1:0]  acc_half;
  logic signed [ACC_W-1:0]  acc_shift;
  logic signed [VAL_W-1:0]  acc_sat;

  mme_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_DIM)
  ) u_bcol (
    .clk    (clk),
    .wr_en  (wr.en && (int'(wr.col) == COL)),
    .wr_addr(RAW'(wr.row)),
    .wr_data(wr.value),
    .rd_addr(RAW'(tok_in.k)),
    .rd_data(b_raw)
  );

  // Stage 1: the token is registered while its B entry is read.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok1 <= '0;
    end else begin
      tok1 <= tok_in;
    end
  end

  assign tok_out = tok1;

  // Stage 2: product.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= tok1.valid;
    end
    first2 <= tok1.first;
    last2  <= tok1.last;
    prod   <= tok1.a * $signed(b_raw);
  end

  // Stage 3: accumulate; the first term of a sum restarts it.
  always_ff @(posedge clk) begin
    if (rst) begin
      done3 <= 1'b0;
    end else begin
      done3 <= v2 && last2;
    end
    if (v2) begin
      acc <= first2 ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // Round half up to the Q8.8 grid, then saturate.
  always_comb begin
    acc_half  = acc + HALF;
    acc_shift = acc_half >>> FRAC_BITS;
    if (acc_shift > SAT_HI) begin
      acc_sat = SAT_HI[VAL_W-1:0];
    end else if (acc_shift < SAT_LO) begin
      acc_sat = SAT_LO[VAL_W-1:0];
    end else begin
      acc_sat = acc_shift[VAL_W-1:0];
    end
  end

  // Stage 4: finished result, held until the next row clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (clr) begin
      res_valid <= 1'b0;
    end else if (done3) begin
      res_valid <= 1'b1;
    end
    if (done3) begin
      res_value <= acc_sat;
    end
  end

endmodule

// ===== hw/rtl/matrix_multiply_engine_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_engine_unit: Q8.8 matrix product over loaded A and B
// A load request is taken whenever the block is idle. A compute request streams
// each row of A through a chain of column cells and emits the result row by row.
// A result row is fed as inner_len reads of A, one element per cycle; the
// results of the row are then sent one column at a time, as the output side
// accepts them. The next request is taken once the last result of the matrix
// has been loaded into the output register.
// Reset clears control state and sets all dimensions to 1; the A and B
// stores hold no defined content until written.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_unit import mme_pkg::*; #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // elem_row, elem_col, elem_value, zero pad
  input  logic [1:0]           s_tuser,   // req_type
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // out_row, out_col, out_value, zero pad
  output logic                 m_tlast,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);
  localparam int ADDR_W  = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int CELL_IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FEED  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  logic [DIM_W-1:0] a_rows, inner_len, b_cols;
  logic [DIM_W-1:0] nr, nk, nc;

  state_t           state;
  logic [DIM_W-1:0] row_i, k_cnt, ptr;
  logic             feed_vld, feed_first, feed_last;
  logic [DIM_W-1:0] feed_k;

  logic [IDX_W-1:0]        in_row, in_col;
  logic signed [VAL_W-1:0] in_value;
  logic                    accept, load_ok, a_we;
  logic [ADDR_W-1:0]       a_waddr, a_raddr;
  logic [VAL_W-1:0]        a_rdata;
  mme_wr_t                 bwr;
  mme_tok_t                tok [MAX_DIM];
  mme_tok_t                feed_tok;
  logic                    clr, out_load, last_col, last_row;

  logic signed [VAL_W-1:0] res_value [MAX_DIM];
  logic [MAX_DIM-1:0]      res_valid;
  logic [CELL_IW-1:0]      ptr_idx;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows    <= DIM_W'(1);
      inner_len <= DIM_W'(1);
      b_cols    <= DIM_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_A_ROWS:    a_rows    <= cfg_data;
        REG_INNER_LEN: inner_len <= cfg_data;
        REG_B_COLS:    b_cols    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign nr = clamp_dim(a_rows);
  assign nk = clamp_dim(inner_len);
  assign nc = clamp_dim(b_cols);

  assign in_row   = s_tdata[2:0];
  assign in_col   = s_tdata[5:3];
  assign in_value = s_tdata[21:6];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load_ok  = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign a_we     = accept && (s_tuser == REQ_LOAD_A) && load_ok;
  assign a_waddr  = ADDR_W'(int'(in_row) * MAX_DIM + int'(in_col));
  assign a_raddr  = ADDR_W'(int'(row_i) * MAX_DIM + int'(k_cnt));

  assign bwr.en    = accept && (s_tuser == REQ_LOAD_B) && load_ok;
  assign bwr.row   = in_row;
  assign bwr.col   = in_col;
  assign bwr.value = in_value;

  mme_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_DIM * MAX_DIM)
  ) u_astore (
    .clk    (clk),
    .wr_en  (a_we),
    .wr_addr(a_waddr),
    .wr_data(in_value),
    .rd_addr(a_raddr),
    .rd_data(a_rdata)
  );

  // The first read of a row also clears every cell's finished result, before
  // the earliest point where the output side looks at them.
  assign clr = (state == ST_FEED) && (k_cnt == '0);

  assign ptr_idx  = CELL_IW'(ptr);
  assign last_col = (ptr == nc - DIM_W'(1));
  assign last_row = (row_i == nr - DIM_W'(1));
  assign out_load = (state == ST_DRAIN) && res_valid[ptr_idx] && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row_i <= '0;
      k_cnt <= '0;
      ptr   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (s_tuser == REQ_COMPUTE)) begin
            row_i <= '0;
            k_cnt <= '0;
            state <= ST_FEED;
          end
        end
        ST_FEED: begin
          k_cnt <= k_cnt + DIM_W'(1);
          if (k_cnt == nk - DIM_W'(1)) begin
            ptr   <= '0;
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_load) begin
            if (last_col) begin
              if (last_row) begin
                state <= ST_IDLE;
              end else begin
                row_i <= row_i + DIM_W'(1);
                k_cnt <= '0;
                state <= ST_FEED;
              end
            end else begin
              ptr <= ptr + DIM_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Element flags are registered alongside the A read, in step with its data.
  always_ff @(posedge clk) begin
    if (rst) begin
      feed_vld <= 1'b0;
    end else begin
      feed_vld <= (state == ST_FEED);
    end
    feed_first <= (k_cnt == '0);
    feed_last  <= (k_cnt == nk - DIM_W'(1));
    feed_k     <= k_cnt;
  end

  assign feed_tok.valid = feed_vld;
  assign feed_tok.first = feed_first;
  assign feed_tok.last  = feed_last;
  assign feed_tok.k     = feed_k;
  assign feed_tok.a     = a_rdata;

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    mme_cell #(
      .COL      (j),
      .MAX_DIM  (MAX_DIM),
      .FRAC_BITS(FRAC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clr      (clr),
      .wr       (bwr),
      .tok_in   ((j == 0) ? feed_tok : tok[(j == 0) ? 0 : j - 1]),
      .tok_out  (tok[j]),
      .res_value(res_value[j]),
      .res_valid(res_valid[j])
    );
  end

  // Output register; it parts the cell chain from the result stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (out_load) begin
      m_tdata <= {2'b00, res_value[ptr_idx], IDX_W'(ptr), IDX_W'(row_i)};
      m_tlast <= last_col && last_row;
    end
  end

endmodule

// ===== hw/rtl/mme_checker.sv =====
// ----------------------------------------------------------------------------
// mme_checker: port-level checks of the matrix multiply engine
// Watches the request, result and reset behavior seen at the top level.
// ----------------------------------------------------------------------------
module mme_checker import mme_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);

  // A stalled result holds its value and marker.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A compute request closes the request side once it is accepted.
  a_busy_after_compute: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == REQ_COMPUTE) |=> !s_tready)
    else $error("request taken while computing");

  // While a result that is not the last one is shown, no request is taken.
  a_busy_mid_matrix: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("request side open in the middle of a result matrix");

  // Any request other than compute produces no result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser != REQ_COMPUTE) && !m_tvalid |=> !m_tvalid)
    else $error("result after a non-compute request");

endmodule

bind matrix_multiply_engine_unit mme_checker u_mme_checker (.*);

// ===== verif/mme_product_checker.sv =====
// ----------------------------------------------------------------------------
// mme_product_checker: result checker for the matrix multiply engine
// Watches the register port, the request stream and the result stream. It
// keeps its own copy of the A and B stores and the dimension registers,
// computes the expected product elements for each compute request, and
// compares every result element against the oldest expected one.
// ----------------------------------------------------------------------------
module mme_product_checker import mme_pkg::*; #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [23:0]          s_tdata,   // elem_row, elem_col, elem_value, zero pad
  input  logic [1:0]           s_tuser,   // req_type
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [23:0]          m_tdata,   // out_row, out_col, out_value, zero pad
  input  logic                 m_tlast,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   elems_pending
);

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } elem_t;

  elem_t                   expected_elems[$];
  logic signed [VAL_W-1:0] a_mat[MAX_DIM*MAX_DIM];
  logic signed [VAL_W-1:0] b_mat[MAX_DIM*MAX_DIM];
  logic [DIM_W-1:0]        rows_reg;
  logic [DIM_W-1:0]        inner_reg;
  logic [DIM_W-1:0]        cols_reg;

  // A dimension of zero behaves as one, anything above MAX_DIM as MAX_DIM.
  function automatic int eff_dim(input logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  // Queue every element of A * B in row-major order.
  task automatic predict_product();
    int    nr, nk, nc;
    longint acc;
    elem_t e;
    nr = eff_dim(rows_reg);
    nk = eff_dim(inner_reg);
    nc = eff_dim(cols_reg);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        for (int k = 0; k < nk; k++)
          acc += longint'(a_mat[i*MAX_DIM+k]) * longint'(b_mat[k*MAX_DIM+j]);
        // Half an LSB up, then floor, then clip to the Q8.8 range.
        if (FRAC_BITS > 0) acc += longint'(1) << (FRAC_BITS > 0 ? FRAC_BITS - 1 : 0);
        acc = acc >>> FRAC_BITS;
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        e.row   = IDX_W'(i);
        e.col   = IDX_W'(j);
        e.value = VAL_W'(acc);
        e.last  = (i == nr - 1) && (j == nc - 1);
        expected_elems.insert(expected_elems.size(), e);
      end
    end
  endtask

  always @(posedge clk) begin
    elem_t got;
    elem_t want;
    int    idx;
    bit    in_range;
    if (rst) begin
      rows_reg  = 1;
      inner_reg = 1;
      cols_reg  = 1;
      expected_elems.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.row   = m_tdata[2:0];
        got.col   = m_tdata[5:3];
        got.value = m_tdata[21:6];
        got.last  = m_tlast;
        if (expected_elems.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] unexpected result: row %0d col %0d value %0d last %0b",
                     $realtime, got.row, got.col, got.value, got.last);
          mismatches++;
        end else begin
          want = expected_elems.pop_front();
          if (got.row !== want.row || got.col !== want.col ||
              got.value !== want.value || got.last !== want.last) begin
            if (mismatches < 10)
              $display({"[%0t] result mismatch: expected row %0d col %0d value %0d",
                        " last %0b, got row %0d col %0d value %0d last %0b"},
                       $realtime, want.row, want.col, want.value, want.last,
                       got.row, got.col, got.value, got.last);
            mismatches++;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_A_ROWS:    rows_reg  = cfg_data;
          REG_INNER_LEN: inner_reg = cfg_data;
          REG_B_COLS:    cols_reg  = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        idx      = int'(s_tdata[2:0]) * MAX_DIM + int'(s_tdata[5:3]);
        // An element outside the stores is dropped.
        in_range = (int'(s_tdata[2:0]) < MAX_DIM) && (int'(s_tdata[5:3]) < MAX_DIM);
        case (s_tuser)
          REQ_LOAD_A:  if (in_range) a_mat[idx] = s_tdata[21:6];
          REQ_LOAD_B:  if (in_range) b_mat[idx] = s_tdata[21:6];
          REQ_COMPUTE: predict_product();
          default: ;
        endcase
      end
    end
    elems_pending = expected_elems.size();
  end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: top-level testbench of matrix_multiply_engine_unit
// Drives load and compute requests with random source and sink stalls across
// a series of matrix shapes, including zero and oversized dimensions, and
// reports the verdict from the product checker.
// ----------------------------------------------------------------------------
module tb;
  import mme_pkg::*;

  localparam int         MAX_DIM    = 8;
  localparam int         N_PHASES   = 10;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [23:0]          s_tdata;   // elem_row, elem_col, elem_value, zero pad
  logic [1:0]           s_tuser;   // req_type
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [23:0]          m_tdata;   // out_row, out_col, out_value, zero pad
  logic                 m_tlast;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  int mismatches;
  int elems_pending;
  int tx_idle_pct = 14;
  int rx_idle_pct = 70;
  int rows_eff, inner_eff, cols_eff;
  bit a_loaded[MAX_DIM*MAX_DIM];
  bit b_loaded[MAX_DIM*MAX_DIM];

  matrix_multiply_engine_unit #(.MAX_DIM(MAX_DIM), .FRAC_BITS(8)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mme_product_checker #(.MAX_DIM(MAX_DIM), .FRAC_BITS(8)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .elems_pending(elems_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_req(input logic [1:0] req, input logic [2:0] row,
                          input logic [2:0] col, input logic [15:0] val);
    @(negedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tdata  = {2'b00, val, col, row};
    s_tuser  = req;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    if (req == REQ_LOAD_A) a_loaded[row*MAX_DIM+col] = 1'b1;
    if (req == REQ_LOAD_B) b_loaded[row*MAX_DIM+col] = 1'b1;
  endtask

  // Hold off new requests until every result element is back and the block
  // has had time to finish any trailing load.
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (elems_pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic int clamp_dim(input logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  task automatic set_dims(input logic [DIM_W-1:0] nr, input logic [DIM_W-1:0] nk,
                          input logic [DIM_W-1:0] nc);
    drain();
    write_reg(REG_A_ROWS, nr);
    write_reg(REG_INNER_LEN, nk);
    write_reg(REG_B_COLS, nc);
    rows_eff  = clamp_dim(nr);
    inner_eff = clamp_dim(nk);
    cols_eff  = clamp_dim(nc);
  endtask

  function automatic logic [15:0] rand_val();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(1023) - 512);
      2: case ($urandom_range(4))
           0: return 16'h7fff;
           1: return 16'h8000;
           2: return 16'h0000;
           3: return 16'h0001;
           default: return 16'hffff;
         endcase
      default: return 16'($urandom_range(8191) - 4096);
    endcase
  endfunction

  // A compute may only read elements that have been loaded at least once.
  function automatic bit operands_loaded();
    for (int i = 0; i < rows_eff; i++)
      for (int k = 0; k < inner_eff; k++)
        if (!a_loaded[i*MAX_DIM+k]) return 1'b0;
    for (int k = 0; k < inner_eff; k++)
      for (int j = 0; j < cols_eff; j++)
        if (!b_loaded[k*MAX_DIM+j]) return 1'b0;
    return 1'b1;
  endfunction

  // Fill a missing operand of the current shape, or refresh a random one.
  task automatic load_operand();
    int i, k, j;
    for (i = 0; i < rows_eff; i++)
      for (k = 0; k < inner_eff; k++)
        if (!a_loaded[i*MAX_DIM+k]) begin
          send_req(REQ_LOAD_A, 3'(i), 3'(k), rand_val());
          return;
        end
    for (k = 0; k < inner_eff; k++)
      for (j = 0; j < cols_eff; j++)
        if (!b_loaded[k*MAX_DIM+j]) begin
          send_req(REQ_LOAD_B, 3'(k), 3'(j), rand_val());
          return;
        end
    k = $urandom_range(inner_eff - 1);
    if ($urandom_range(1))
      send_req(REQ_LOAD_A, 3'($urandom_range(rows_eff - 1)), 3'(k), rand_val());
    else
      send_req(REQ_LOAD_B, 3'(k), 3'($urandom_range(cols_eff - 1)), rand_val());
  endtask

  initial begin
    int n_items, n_computes, pick;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed: saturation both ways, rounding of exact halves, ignored
    // request type, and the highest element indexes.
    set_dims(4'd1, 4'd1, 4'd1);
    send_req(REQ_LOAD_A, 3'd0, 3'd0, 16'h7fff);
    send_req(REQ_LOAD_B, 3'd0, 3'd0, 16'h7fff);
    send_req(REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);
    send_req(REQ_LOAD_A, 3'd0, 3'd0, 16'h8000);
    send_req(REQ_LOAD_B, 3'd0, 3'd0, 16'h8000);
    send_req(REQ_COMPUTE, 3'h7, 3'h7, 16'hffff);
    send_req(REQ_LOAD_B, 3'd0, 3'd0, 16'h7fff);
    send_req(REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);
    send_req(REQ_LOAD_A, 3'd0, 3'd0, 16'h0001);
    send_req(REQ_LOAD_B, 3'd0, 3'd0, 16'h0080);
    send_req(REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);
    send_req(REQ_LOAD_A, 3'd0, 3'd0, 16'hffff);
    send_req(REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);
    send_req(REQ_LOAD_B, 3'd0, 3'd0, 16'h0081);
    send_req(REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);
    send_req(REQ_UNUSED, 3'h7, 3'h7, 16'hffff);
    send_req(REQ_LOAD_A, 3'h7, 3'h7, 16'h0000);
    send_req(REQ_LOAD_B, 3'h7, 3'h7, 16'h5a5a);
    send_req(REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 4) begin
        tx_idle_pct = 14;
        rx_idle_pct = 70;
      end else if (ph < 7) begin
        tx_idle_pct = 70;
        rx_idle_pct = 14;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (ph)
        0: set_dims(4'd0, 4'd0, 4'd0);
        1: set_dims(4'd1, 4'd8, 4'd1);
        2: set_dims(4'd15, 4'd15, 4'd15);
        3: set_dims(4'd8, 4'd1, 4'd8);
        4: set_dims(4'd8, 4'd8, 4'd8);
        default: begin
          if ($urandom_range(3) == 0)
            set_dims(4'($urandom_range(15)), 4'($urandom_range(15)), 4'($urandom_range(15)));
          else
            set_dims(4'($urandom_range(4)), 4'($urandom_range(4)), 4'($urandom_range(4)));
        end
      endcase

      n_items    = 0;
      n_computes = 0;
      while (n_items < 18 || n_computes < 2) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          send_req(REQ_UNUSED, 3'($urandom), 3'($urandom), 16'($urandom));
        end else begin
          if (pick < 18) begin
            send_req($urandom_range(1) ? REQ_LOAD_B : REQ_LOAD_A,
                     3'($urandom), 3'($urandom), rand_val());
          end else if (pick < 40 && operands_loaded()) begin
            send_req(REQ_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
            n_computes++;
          end else begin
            load_operand();
          end
          n_items++;
        end
      end
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (elems_pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
